// ----- src/fpws_pkg.sv -----
// ----------------------------------------------------------------------------
// Flash page write splitter package
// Shared widths, codes and types for the page write splitter.
// ----------------------------------------------------------------------------
package fpws_pkg;

   localparam int ADDR_W = 32;
   localparam int LEN_W  = 13;
   localparam int SRC_W  = 12;
   localparam int PAD_W  = 2;
   localparam int LG_W   = 4;

   localparam int LEN_LIMIT_W = 17;
   localparam logic [LEN_LIMIT_W-1:0] MAX_LENGTH = 17'd4096;

   localparam logic [LG_W-1:0] PAGE_LG_MIN   = 4'd8;
   localparam logic [LG_W-1:0] PAGE_LG_MAX   = 4'd12;
   localparam logic [LG_W-1:0] PAGE_LG_RESET = 4'd8;

   localparam logic [LEN_W-1:0] PAD_OP_LEN = 13'd2;

   typedef enum logic [PAD_W-1:0] {
      PAD_NONE  = 2'd0,
      PAD_LEAD  = 2'd1,
      PAD_TRAIL = 2'd2
   } pad_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LEAD  = 4'b0010,
      ST_BODY  = 4'b0100,
      ST_TRAIL = 4'b1000
   } seq_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic [LEN_W-1:0]  remaining;
      logic [LG_W-1:0]   page_lg;
   } chunk_req_type;

endpackage

// ----- src/fpws_chunk_unit.sv -----
// ----------------------------------------------------------------------------
// Chunk unit
// Size of the next page-bounded program operation: bytes to the page end,
// limited by the bytes still to go.
// ----------------------------------------------------------------------------
module fpws_chunk_unit
   import fpws_pkg::*;
(
   input  chunk_req_type     chunk_req,
   output logic [LEN_W-1:0]  chunk_len
);

   logic [LG_W-1:0]  lg_clamped;
   logic [LEN_W-1:0] page_bytes;
   logic [LEN_W-1:0] page_off;
   logic [LEN_W-1:0] to_bound;

   always_comb begin
      if (chunk_req.page_lg < PAGE_LG_MIN) begin
         lg_clamped = PAGE_LG_MIN;
      end else if (chunk_req.page_lg > PAGE_LG_MAX) begin
         lg_clamped = PAGE_LG_MAX;
      end else begin
         lg_clamped = chunk_req.page_lg;
      end
      page_bytes = LEN_W'(1) << lg_clamped;
      page_off   = chunk_req.offset[LEN_W-1:0] & (page_bytes - LEN_W'(1));
      to_bound   = page_bytes - page_off;
      chunk_len  = (to_bound > chunk_req.remaining) ? chunk_req.remaining
                                                     : to_bound;
   end

endmodule

// ----- src/flash_page_write_splitter_top.sv -----
// ----------------------------------------------------------------------------
// Flash page write splitter
// Breaks one write request into page-bounded even program operations.
// ----------------------------------------------------------------------------
// One request transfer (start offset, byte count) yields its program operations
// in order, one per cycle while the result side takes them: an optional
// leading-pad op, page-bounded body ops, an optional trailing-pad op, the final
// one marked by rsp_tlast. A request yields up to 19 operations at the largest
// count and smallest page, paced by the single chunk unit that sizes each body
// op; req_tready is low until the last operation has been handed to the output
// register. A zero count yields nothing.
// ----------------------------------------------------------------------------
module flash_page_write_splitter_top
   import fpws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,   // page_size_log2
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,     // start_offset[31:0], byte_count[44:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,     // op_address[31:0], op_length[44:32],
                                      // source_index[56:45]
   output logic [1:0]  rsp_tuser,     // pad_kind[1:0]
   output logic        rsp_tlast
);

   seq_state_type     state_ff, state_in;
   logic [LG_W-1:0]   page_lg_ff;
   logic [ADDR_W-1:0] offs_ff, offs_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  src_ff, src_in;
   logic              odd_end_ff, odd_end_in;

   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [SRC_W-1:0]  rsp_src_ff, rsp_src_in;
   pad_kind_type      rsp_pad_ff, rsp_pad_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [ADDR_W-1:0] req_offset;
   logic [LEN_W-1:0]  req_count;
   logic [LEN_W-1:0]  count_clip;
   logic [LEN_W-1:0]  count_after_lead;
   logic              req_xfer;
   logic              advance;
   chunk_req_type     chunk_req;
   logic [LEN_W-1:0]  chunk_len;
   logic [LEN_W-1:0]  rem_after;

   assign req_offset = req_tdata[31:0];
   assign req_count  = req_tdata[44:32];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign advance    = (state_ff != ST_IDLE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (LEN_LIMIT_W'(req_count) > MAX_LENGTH) begin
         count_clip = LEN_W'(MAX_LENGTH);
      end else begin
         count_clip = req_count;
      end
      count_after_lead = count_clip - LEN_W'(req_offset[0]);
   end

   assign chunk_req.offset    = offs_ff;
   assign chunk_req.remaining = rem_ff;
   assign chunk_req.page_lg   = page_lg_ff;

   fpws_chunk_unit u_chunk (
      .chunk_req (chunk_req),
      .chunk_len (chunk_len)
   );

   assign rem_after = rem_ff - chunk_len;

   always_comb begin
      state_in    = state_ff;
      offs_in     = offs_ff;
      rem_in      = rem_ff;
      src_in      = src_ff;
      odd_end_in  = odd_end_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_src_in  = rsp_src_ff;
      rsp_pad_in  = rsp_pad_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (count_clip != '0)) begin
               offs_in    = req_offset + ADDR_W'(req_offset[0]);
               src_in     = LEN_W'(req_offset[0]);
               odd_end_in = count_after_lead[0];
               rem_in     = {count_after_lead[LEN_W-1:1], 1'b0};
               if (req_offset[0]) begin
                  state_in = ST_LEAD;
               end else if (count_after_lead[LEN_W-1:1] != '0) begin
                  state_in = ST_BODY;
               end else begin
                  state_in = ST_TRAIL;
               end
            end
         end
         ST_LEAD: begin
            if (advance) begin
               rsp_addr_in = offs_ff - ADDR_W'(2);
               rsp_len_in  = PAD_OP_LEN;
               rsp_src_in  = '0;
               rsp_pad_in  = PAD_LEAD;
               rsp_last_in = (rem_ff == '0) && !odd_end_ff;
               if (rem_ff != '0) begin
                  state_in = ST_BODY;
               end else if (odd_end_ff) begin
                  state_in = ST_TRAIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BODY: begin
            if (advance) begin
               rsp_addr_in = offs_ff;
               rsp_len_in  = chunk_len;
               rsp_src_in  = src_ff[SRC_W-1:0];
               rsp_pad_in  = PAD_NONE;
               rsp_last_in = (rem_after == '0) && !odd_end_ff;
               offs_in     = offs_ff + ADDR_W'(chunk_len);
               src_in      = src_ff + chunk_len;
               rem_in      = rem_after;
               if (rem_after != '0) begin
                  state_in = ST_BODY;
               end else if (odd_end_ff) begin
                  state_in = ST_TRAIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TRAIL: begin
            if (advance) begin
               rsp_addr_in = offs_ff;
               rsp_len_in  = PAD_OP_LEN;
               rsp_src_in  = src_ff[SRC_W-1:0];
               rsp_pad_in  = PAD_TRAIL;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         page_lg_ff   <= PAGE_LG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            page_lg_ff <= csr_wr_data;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      offs_ff     <= offs_in;
      rem_ff      <= rem_in;
      src_ff      <= src_in;
      odd_end_ff  <= odd_end_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_src_ff  <= rsp_src_in;
      rsp_pad_ff  <= rsp_pad_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_src_ff, rsp_len_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_pad_ff;
   assign rsp_tlast  = rsp_last_ff;

   // padded ops are always two bytes
   a_pad_len : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_pad_ff != PAD_NONE) |-> rsp_len_ff == PAD_OP_LEN)
      else $error("padded op length not two");

   // trailing pad closes the request
   a_trail_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_pad_ff == PAD_TRAIL) |-> rsp_last_ff)
      else $error("trailing pad op not last");

   // body ops are even in address and length
   a_body_even : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_pad_ff == PAD_NONE) |-> !rsp_addr_ff[0] && !rsp_len_ff[0]
         && (rsp_len_ff != '0))
      else $error("odd or empty body op");

   // no request is taken while operations are still being produced
   a_busy_block : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready && !(rsp_valid_ff && rsp_last_ff && !rsp_tready
         && advance))
      else $error("request overlap");

endmodule

// ----- tb/sv/fpws_checker.sv -----
// ----------------------------------------------------------------------------
// Flash page write splitter checker
// Watches the request, result and register ports of the splitter. For every
// request transfer it computes the program operations the flash needs and
// compares each result transfer, field by field, with the oldest one pending.
// ----------------------------------------------------------------------------
module fpws_checker
   import fpws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending,
   output int          n_reqs,
   output int          n_ops,
   output int          n_lead,
   output int          n_trail
);

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      logic [SRC_W-1:0]  src;
      pad_kind_type      pad;
      logic              last;
   } program_op_type;

   program_op_type  pending_ops[$];
   logic [LG_W-1:0] page_lg;
   int              errors;
   int              reqs_seen;
   int              ops_seen;
   int              lead_seen;
   int              trail_seen;

   function automatic program_op_type make_op(logic [ADDR_W-1:0] addr,
                                              logic [LEN_W-1:0] len,
                                              logic [SRC_W-1:0] src, pad_kind_type pad);
      program_op_type op;
      op.addr = addr;
      op.len  = len;
      op.src  = src;
      op.pad  = pad;
      op.last = 1'b0;
      return op;
   endfunction

   // program ops for one write: lead pad for an odd start, page-bounded even
   // body, trail pad for a leftover odd byte
   function automatic void split_request(logic [ADDR_W-1:0] offset, logic [LEN_W-1:0] count);
      program_op_type    plan[$];
      program_op_type    op;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  left;
      logic [SRC_W-1:0]  src;
      logic [LG_W-1:0]   lg;
      logic [31:0]       page;
      logic [31:0]       chunk;
      logic              odd_tail;
      left = (count > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : count;
      if (left == '0) return;
      lg = page_lg;
      if (lg < PAGE_LG_MIN) lg = PAGE_LG_MIN;
      if (lg > PAGE_LG_MAX) lg = PAGE_LG_MAX;
      page = 32'd1 << lg;
      addr = offset;
      src  = '0;
      if (addr[0]) begin
         plan.push_back(make_op(addr - 32'd1, PAD_OP_LEN, '0, PAD_LEAD));
         addr = addr + 32'd1;
         src  = 12'd1;
         left = left - 13'd1;
      end
      odd_tail = left[0];
      left     = left - LEN_W'(odd_tail);
      while (left != '0) begin
         chunk = page - (addr & (page - 32'd1));
         if (chunk > 32'(left)) chunk = 32'(left);
         plan.push_back(make_op(addr, chunk[LEN_W-1:0], src, PAD_NONE));
         addr = addr + chunk;
         src  = src + chunk[SRC_W-1:0];
         left = left - chunk[LEN_W-1:0];
      end
      if (odd_tail) plan.push_back(make_op(addr, PAD_OP_LEN, src, PAD_TRAIL));
      op = plan[plan.size() - 1];
      op.last = 1'b1;
      plan[plan.size() - 1] = op;
      foreach (plan[i]) pending_ops.push_back(plan[i]);
   endfunction

   always @(posedge clock) begin
      program_op_type got;
      program_op_type exp_op;
      if (reset) begin
         page_lg = PAGE_LG_RESET;
         pending_ops.delete();
      end else begin
         if (csr_wr_en) page_lg = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.addr = rsp_tdata[31:0];
            got.len  = rsp_tdata[44:32];
            got.src  = rsp_tdata[56:45];
            got.pad  = pad_kind_type'(rsp_tuser);
            got.last = rsp_tlast;
            ops_seen++;
            if (got.pad == PAD_LEAD) lead_seen++;
            if (got.pad == PAD_TRAIL) trail_seen++;
            if (pending_ops.size() == 0) begin
               if (errors < 10)
                  $display("fpws_checker: unexpected op addr=%h len=%0d src=%0d",
                           got.addr, got.len, got.src,
                           " pad=%0d last=%0b", got.pad, got.last);
               errors++;
            end else begin
               exp_op = pending_ops.pop_front();
               if (got.addr !== exp_op.addr || got.len !== exp_op.len ||
                   got.src !== exp_op.src || got.pad !== exp_op.pad ||
                   got.last !== exp_op.last) begin
                  if (errors < 10) begin
                     $display("fpws_checker: op mismatch exp addr=%h len=%0d src=%0d",
                              exp_op.addr, exp_op.len, exp_op.src,
                              " pad=%0d last=%0b", exp_op.pad, exp_op.last);
                     $display("fpws_checker:             got addr=%h len=%0d src=%0d",
                              got.addr, got.len, got.src,
                              " pad=%0d last=%0b", got.pad, got.last);
                  end
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            reqs_seen++;
            split_request(req_tdata[31:0], req_tdata[44:32]);
         end
      end
      fail_count <= errors;
      pending    <= pending_ops.size();
      n_reqs     <= reqs_seen;
      n_ops      <= ops_seen;
      n_lead     <= lead_seen;
      n_trail    <= trail_seen;
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Flash page write splitter testbench
// Drives directed and random write requests across several page sizes, with
// random gaps on both channels and one long result-side stall; the checker
// predicts and compares every program op.
// ----------------------------------------------------------------------------
module tb_top
   import fpws_pkg::*;
();

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [3:0]  csr_wr_data = PAGE_LG_RESET;
   logic        req_tvalid  = 1'b0;
   logic [47:0] req_tdata   = '0;
   logic        rsp_tready  = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int fail_count;
   int pending;
   int n_reqs;
   int n_ops;
   int n_lead;
   int n_trail;

   bit tx_burst    = 1'b0;
   bit rx_burst    = 1'b0;
   bit rx_hold_req = 1'b0;

   flash_page_write_splitter_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   fpws_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .pending     (pending),
      .n_reqs      (n_reqs),
      .n_ops       (n_ops),
      .n_lead      (n_lead),
      .n_trail     (n_trail)
   );

   always #4 clock = ~clock;

   task automatic send_write(logic [31:0] offset, logic [12:0] count);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, count, offset};
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic drain_ops();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_page_lg(logic [3:0] value);
      drain_ops();
      repeat (25) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(int n_items);
      int          i;
      int          pick;
      logic [31:0] offset;
      logic [12:0] count;
      for (i = 0; i < n_items; i++) begin
         if (i % 6 == 0) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 9);
         if (pick < 6)
            offset = $urandom;
         else if (pick < 9)
            offset = ($urandom & 32'hffff_f000) - 32'd3 + $urandom_range(0, 6);
         else
            offset = 32'hffff_ffff - $urandom_range(0, 8);
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3, 4, 5: count = 13'($urandom_range(1, 40));
            6, 7:             count = 13'($urandom_range(41, 4096));
            8:                count = 13'($urandom_range(4097, 8191));
            default:          count = $urandom_range(0, 1) ? 13'd0 : 13'd4096;
         endcase
         send_write(offset, count);
      end
      req_tvalid <= 1'b0;
   endtask

   // result side: random stall per op, or one long hold-off on request
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            n = 400;
         end else begin
            n = rx_burst ? 0 : $urandom_range(0, 10);
         end
         if (n != 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      #4000000;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset page size
      send_write(32'h0000_0000, 13'd0);
      send_write(32'h0000_0001, 13'd1);
      send_write(32'hffff_ffff, 13'd1);
      send_write(32'hffff_ffff, 13'd3);
      send_write(32'hffff_fffe, 13'd4096);
      send_write(32'h0000_0000, 13'd4096);
      send_write(32'h0000_0081, 13'd4096);
      send_write(32'h0000_0010, 13'd8191);
      send_write(32'h0000_0003, 13'd4097);
      send_write(32'hffff_ffff, 13'd8191);
      send_write(32'h0000_00fe, 13'd2);
      send_write(32'h0000_00ff, 13'd2);
      send_write(32'h0000_0100, 13'd5);
      send_write(32'h1234_5677, 13'd1000);
      send_write(32'h0000_0002, 13'd255);
      send_write(32'haaaa_5555, 13'd4095);
      req_tvalid <= 1'b0;

      write_page_lg(4'd12);
      send_write(32'h0000_0fff, 13'd4096);
      send_write(32'h0000_0ffe, 13'd4);
      req_tvalid <= 1'b0;
      run_random(14);

      write_page_lg(4'd0);
      run_random(14);

      write_page_lg(4'd15);
      run_random(14);

      write_page_lg(4'd9);
      // long result stall while requests keep coming
      rx_hold_req = 1'b1;
      tx_burst    = 1'b1;
      send_write(32'h0000_01ff, 13'd2048);
      send_write(32'h0000_0001, 13'd7);
      send_write(32'h0000_0300, 13'd600);
      send_write(32'h0000_0005, 13'd9);
      req_tvalid <= 1'b0;
      run_random(14);

      write_page_lg(4'd10);
      run_random(14);

      write_page_lg(4'd11);
      run_random(14);

      write_page_lg(4'd8);
      run_random(14);

      drain_ops();
      repeat (30) @(posedge clock);
      $display("tb_top: %0d write requests, %0d program ops (%0d lead pad, %0d trail pad)",
               n_reqs, n_ops, n_lead, n_trail);
      $display("tb_top: page codes 8,12,0,15,9,10,11,8; clipped counts, wraps, long stall");
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/fpws_pkg.sv
src/fpws_chunk_unit.sv
src/flash_page_write_splitter_top.sv
tb/sv/fpws_checker.sv
tb/sv/tb_top.sv
